>>> hw/rtl/alb_pkg.sv
// ----------------------------------------------------------------------------
// alb_pkg
// Shared types, codes and constants for the address lockout backoff table.
// ----------------------------------------------------------------------------
`default_nettype none

package alb_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;

   localparam int OP_W      = 2;
   localparam int ADDR_W    = 32;
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 8;
   localparam int THR_W     = 8;
   localparam int SECS_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   // operation codes
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
   localparam logic [OP_W-1:0] OP_FAILURE = 2'd1;
   localparam logic [OP_W-1:0] OP_SUCCESS = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FAIL_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BAN_INITIAL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BAN_MAX        = 2'd2;

   localparam logic [THR_W-1:0]  FAIL_THRESHOLD_RESET = 8'd5;
   localparam logic [SECS_W-1:0] BAN_INITIAL_RESET    = 24'd60;
   localparam logic [SECS_W-1:0] BAN_MAX_RESET        = 24'd3600;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic               valid;
      logic               active;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] level;
      logic [TIME_W-1:0]  expiry;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_BACKOFF,
      ST_CAP,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic capture;
      logic scan_step;
      logic exec;
      logic bo_step;
      logic bo_cap;
      logic commit;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic scan_done;
      logic need_ban;
      logic bo_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/alb_if.sv
// ----------------------------------------------------------------------------
// alb_if
// Valid/ready channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface alb_req_if;
   logic                        valid;
   logic                        ready;
   logic [alb_pkg::OP_W-1:0]    op;
   logic [alb_pkg::ADDR_W-1:0]  source_address;
   logic [alb_pkg::TIME_W-1:0]  current_time;
   modport source (output valid, op, source_address, current_time, input ready);
   modport sink   (input valid, op, source_address, current_time, output ready);
endinterface

interface alb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        is_blocked;
   logic                        banned_now;
   logic [alb_pkg::SECS_W-1:0]  ban_seconds;
   logic                        table_full;
   modport source (output valid, is_blocked, banned_now, ban_seconds, table_full,
                   input ready);
   modport sink   (input valid, is_blocked, banned_now, ban_seconds, table_full,
                   output ready);
endinterface

interface alb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [alb_pkg::CSR_IDX_W-1:0] index;
   logic [alb_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/address_lockout_backoff_table_core.sv
// ----------------------------------------------------------------------------
// address_lockout_backoff_table_core
// Source address lockout table with failure counting and exponential backoff.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                        transfer
//   req_bus   in    op, source_address, current_time               valid & ready
//   rsp_bus   out   is_blocked, banned_now, ban_seconds, table_full valid & ready
//   csr_bus   in    index, data                                    valid & ready
//
// One request in flight; rsp valid rises after the request transfer once the
// linear scan (one registered read per entry) and the update are done.
// A new ban adds the doubling loop, a cap step and a write-back.
// Reset starts a clearing pass; req ready first rises once every entry has been
// cleared. Register writes are taken at any time.
// A waiting result holds in the output register while the next request runs.
//
`default_nettype none

module address_lockout_backoff_table_core #(
   parameter int TABLE_ENTRIES = alb_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   alb_req_if.sink    req_bus,
   alb_rsp_if.source  rsp_bus,
   alb_csr_if.sink    csr_bus
);

   alb_pkg::ctrl_cmd_type  cmd;
   alb_pkg::dp_status_type status;

   // sequencer: owns req ready, steps the datapath
   alb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // entry memory, config registers and result register
   alb_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_bus.valid),
      .csr_ready          (csr_bus.ready),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .req_op             (req_bus.op),
      .req_source_address (req_bus.source_address),
      .req_current_time   (req_bus.current_time),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_is_blocked     (rsp_bus.is_blocked),
      .rsp_banned_now     (rsp_bus.banned_now),
      .rsp_ban_seconds    (rsp_bus.ban_seconds),
      .rsp_table_full     (rsp_bus.table_full)
   );

   // no request is taken during the clearing pass
   a_clear_holds_req : assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_bus.ready)
      else $error("request ready during clearing pass");

   // a transfer on req moves the sequencer off idle
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("second request taken while one is in flight");

   // result loads only into a free output register
   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result overwrote a pending response");

   // at most one outcome flag, and a length only with a new ban
   a_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ($onehot0({rsp_bus.is_blocked, rsp_bus.banned_now,
                                   rsp_bus.table_full}) &&
                         (rsp_bus.banned_now || (rsp_bus.ban_seconds == '0))))
      else $error("inconsistent response flags");

endmodule

`default_nettype wire

>>> hw/rtl/alb_ctrl.sv
// ----------------------------------------------------------------------------
// alb_ctrl
// Sequencer: clear sweep, table scan, update, backoff and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module alb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire alb_pkg::dp_status_type status,
   output alb_pkg::ctrl_cmd_type       cmd
);

   alb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         alb_pkg::ST_CLEAR: begin
            if (status.clr_done) begin
               state_in = alb_pkg::ST_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         alb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = alb_pkg::ST_SCAN;
            end
         end
         alb_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = alb_pkg::ST_EXEC;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         alb_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_ban ? alb_pkg::ST_BACKOFF : alb_pkg::ST_EMIT;
         end
         alb_pkg::ST_BACKOFF: begin
            if (status.bo_done) begin
               state_in = alb_pkg::ST_CAP;
            end else begin
               cmd.bo_step = 1'b1;
            end
         end
         alb_pkg::ST_CAP: begin
            cmd.bo_cap = 1'b1;
            state_in   = alb_pkg::ST_COMMIT;
         end
         alb_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = alb_pkg::ST_EMIT;
         end
         alb_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = alb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alb_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/alb_datapath.sv
// ----------------------------------------------------------------------------
// alb_datapath
// Entry memory, scan compare, update logic, backoff shifter and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module alb_datapath #(
   parameter int TABLE_ENTRIES = alb_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire alb_pkg::ctrl_cmd_type           cmd,
   output alb_pkg::dp_status_type               status,
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [alb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [alb_pkg::CSR_DAT_W-1:0]   csr_data,
   // request payload
   input  wire logic [alb_pkg::OP_W-1:0]        req_op,
   input  wire logic [alb_pkg::ADDR_W-1:0]      req_source_address,
   input  wire logic [alb_pkg::TIME_W-1:0]      req_current_time,
   // response
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_is_blocked,
   output logic                                 rsp_banned_now,
   output logic [alb_pkg::SECS_W-1:0]           rsp_ban_seconds,
   output logic                                 rsp_table_full
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PTR_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [PTR_W-1:0] PTR_END = PTR_W'(TABLE_ENTRIES);
   localparam int SECS_W = alb_pkg::SECS_W;
   localparam int TIME_W = alb_pkg::TIME_W;

   // configuration
   logic [alb_pkg::THR_W-1:0] cfg_thr_ff;
   logic [SECS_W-1:0]         cfg_init_ff;
   logic [SECS_W-1:0]         cfg_max_ff;

   // captured request
   logic [alb_pkg::OP_W-1:0]   op_ff;
   logic [alb_pkg::ADDR_W-1:0] addr_ff;
   logic [TIME_W-1:0]          now_ff;

   // memory
   alb_pkg::entry_type mem [TABLE_ENTRIES];
   alb_pkg::entry_type rd_data_ff;
   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   alb_pkg::entry_type wr_data;

   // sweep and scan
   logic [PTR_W-1:0]   clr_ptr_ff;
   logic [PTR_W-1:0]   scan_ptr_ff;
   logic               chk_vld_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic               found_ff, free_ff;
   logic [IDX_W-1:0]   match_idx_ff, free_idx_ff;
   alb_pkg::entry_type rec_ff;

   // ban path
   alb_pkg::entry_type work_ff;
   logic [IDX_W-1:0]   wslot_ff;
   logic [SECS_W:0]    secs_ff;
   logic [alb_pkg::COUNT_W-1:0] k_ff;

   // result before handoff
   logic              res_blocked_ff, res_banned_ff, res_full_ff;
   logic [SECS_W-1:0] res_secs_ff;

   // output stage
   logic              rsp_valid_ff;
   logic              out_blocked_ff, out_banned_ff, out_full_ff;
   logic [SECS_W-1:0] out_secs_ff;

   // update logic
   alb_pkg::entry_type          base;
   alb_pkg::entry_type          commit_rec;
   logic [alb_pkg::COUNT_W-1:0] cnt_inc;
   logic                        hit_thr, can_fail, expired, query_live;
   logic [IDX_W-1:0]            slot;
   logic [TIME_W:0]             exp_sum;
   logic                        scan_read;

   assign scan_read = cmd.scan_step && (scan_ptr_ff != PTR_END);
   assign rd_en     = scan_read;

   always_comb begin
      if (found_ff) begin
         base = rec_ff;
      end else begin
         base = '{valid: 1'b1, active: 1'b0, address: addr_ff,
                  count: '0, level: '0, expiry: '0};
      end
      cnt_inc    = (base.count == alb_pkg::COUNT_MAX) ? alb_pkg::COUNT_MAX
                                                      : base.count + 1'b1;
      hit_thr    = cnt_inc >= cfg_thr_ff;
      can_fail   = found_ff || free_ff;
      slot       = found_ff ? match_idx_ff : free_idx_ff;
      expired    = rec_ff.expiry <= now_ff;
      query_live = found_ff && rec_ff.active;

      // expiry saturates at the top of the time range
      exp_sum = {1'b0, now_ff} + (TIME_W + 1)'(secs_ff[SECS_W-1:0]);
      commit_rec        = work_ff;
      commit_rec.active = 1'b1;
      commit_rec.count  = '0;
      commit_rec.level  = (work_ff.level == alb_pkg::COUNT_MAX) ? alb_pkg::COUNT_MAX
                                                               : work_ff.level + 1'b1;
      commit_rec.expiry = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
   end

   // memory write select
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = slot;
      wr_data = '0;
      priority if (cmd.clr_step) begin
         wr_en  = 1'b1;
         wr_idx = clr_ptr_ff[IDX_W-1:0];
      end else if (cmd.exec) begin
         unique case (op_ff)
            alb_pkg::OP_QUERY: begin
               // expired ban drops the whole entry
               wr_en  = query_live && expired;
               wr_idx = match_idx_ff;
            end
            alb_pkg::OP_FAILURE: begin
               wr_en         = can_fail && !hit_thr;
               wr_data       = base;
               wr_data.count = cnt_inc;
            end
            alb_pkg::OP_SUCCESS: begin
               wr_en  = found_ff;
               wr_idx = match_idx_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end else if (cmd.commit) begin
         wr_en   = 1'b1;
         wr_idx  = wslot_ff;
         wr_data = commit_rec;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[scan_ptr_ff[IDX_W-1:0]];
      end
   end

   // configuration registers; writes to unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_thr_ff  <= alb_pkg::FAIL_THRESHOLD_RESET;
         cfg_init_ff <= alb_pkg::BAN_INITIAL_RESET;
         cfg_max_ff  <= alb_pkg::BAN_MAX_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            alb_pkg::REG_FAIL_THRESHOLD: cfg_thr_ff  <= csr_data[alb_pkg::THR_W-1:0];
            alb_pkg::REG_BAN_INITIAL:    cfg_init_ff <= csr_data[SECS_W-1:0];
            alb_pkg::REG_BAN_MAX:        cfg_max_ff  <= csr_data[SECS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         chk_vld_ff <= scan_read;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_op;
         addr_ff     <= req_source_address;
         now_ff      <= req_current_time;
         scan_ptr_ff <= '0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
      end else begin
         if (scan_read) begin
            scan_ptr_ff <= scan_ptr_ff + 1'b1;
            chk_idx_ff  <= scan_ptr_ff[IDX_W-1:0];
         end
         if (chk_vld_ff) begin
            if (rd_data_ff.valid && (rd_data_ff.address == addr_ff) && !found_ff) begin
               found_ff     <= 1'b1;
               match_idx_ff <= chk_idx_ff;
               rec_ff       <= rd_data_ff;
            end
            if (!rd_data_ff.valid && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= chk_idx_ff;
            end
         end
      end

      if (cmd.exec) begin
         res_blocked_ff <= (op_ff == alb_pkg::OP_QUERY) && query_live && !expired;
         res_full_ff    <= (op_ff == alb_pkg::OP_FAILURE) && !can_fail;
         res_banned_ff  <= 1'b0;
         res_secs_ff    <= '0;
         work_ff        <= base;
         wslot_ff       <= slot;
         secs_ff        <= {1'b0, cfg_init_ff};
         k_ff           <= '0;
      end else if (cmd.bo_step) begin
         secs_ff <= {secs_ff[SECS_W-1:0], 1'b0};
         k_ff    <= k_ff + 1'b1;
      end else if (cmd.bo_cap) begin
         if (secs_ff > {1'b0, cfg_max_ff}) begin
            secs_ff <= {1'b0, cfg_max_ff};
         end
      end else if (cmd.commit) begin
         res_banned_ff <= 1'b1;
         res_secs_ff   <= secs_ff[SECS_W-1:0];
      end

      if (cmd.emit) begin
         out_blocked_ff <= res_blocked_ff;
         out_banned_ff  <= res_banned_ff;
         out_secs_ff    <= res_secs_ff;
         out_full_ff    <= res_full_ff;
      end
   end

   assign status.clr_done  = clr_ptr_ff == PTR_END;
   assign status.scan_done = (scan_ptr_ff == PTR_END) && !chk_vld_ff;
   assign status.need_ban  = (op_ff == alb_pkg::OP_FAILURE) && can_fail && hit_thr;
   // doubling stops at the level count, at the cap, or when it cannot grow
   assign status.bo_done   = (k_ff == work_ff.level) ||
                             (secs_ff >= {1'b0, cfg_max_ff}) || (secs_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_blocked  = out_blocked_ff;
   assign rsp_banned_now  = out_banned_ff;
   assign rsp_ban_seconds = out_secs_ff;
   assign rsp_table_full  = out_full_ff;

endmodule

`default_nettype wire

>>> test/address_lockout_backoff_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_lockout_backoff_table_core_test
// Drives authentication events (query, failure, success) into the lockout
// table and checks each answer against a predictor of the table built in this
// module: per-address failure counts, ban levels with capped doubling of the
// ban length, expiry handling and table-full drops. Register settings change
// between phases while the core is idle; both channels idle and stall.
// ----------------------------------------------------------------------------

module address_lockout_backoff_table_core_test;

   import alb_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT;

   // op code 3 is not defined by the core; it must answer all zero
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int unsigned HOLD_CYCLES    = 400;  // long receiver hold-off
   localparam int unsigned TAIL_CYCLES    = 64;   // scan + backoff + update
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] address;
      logic [TIME_W-1:0] now;
   } auth_event_type;

   typedef struct packed {
      logic              is_blocked;
      logic              banned_now;
      logic [SECS_W-1:0] ban_seconds;
      logic              table_full;
   } verdict_type;

   typedef struct packed {
      logic               valid;
      logic               active;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] level;
      logic [TIME_W-1:0]  expiry;
   } lockout_slot_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] data;
   } reg_write_type;

   logic clock;
   logic reset;

   alb_req_if req_bus ();
   alb_rsp_if rsp_bus ();
   alb_csr_if csr_bus ();

   address_lockout_backoff_table_core #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state: shadow of the address table and of the registers
   lockout_slot_type   lockout_table [TABLE_ENTRIES];
   logic [THR_W-1:0]   threshold_cfg;
   logic [SECS_W-1:0]  ban_initial_cfg;
   logic [SECS_W-1:0]  ban_cap_cfg;

   auth_event_type pending_events[$];     // filled by the sequencer, drained by driver
   verdict_type    expected_verdicts[$];  // one per accepted event, oldest first
   reg_write_type  pending_writes[$];

   // knobs set by the sequencer while the core is quiet
   bit          source_gaps_on;
   bit          sink_gaps_on;
   int unsigned hold_requests;   // raised by the sequencer
   int unsigned holds_served;    // followed by the result sink
   int unsigned source_wait;
   int unsigned sink_wait;

   int unsigned events_sent;
   int unsigned results_checked;
   int unsigned reg_writes;
   int unsigned settings_used;
   int unsigned bans_started;
   int unsigned blocked_answers;
   int unsigned full_answers;
   int unsigned mismatches;

   // -------------------------------------------------------------------------
   // Queue helpers
   // -------------------------------------------------------------------------
   function automatic void enqueue_verdict(verdict_type v);
      expected_verdicts.insert(expected_verdicts.size(), v);
   endfunction

   function automatic void enqueue_write(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DAT_W-1:0] data);
      reg_write_type w;
      w.index = idx;
      w.data  = data;
      pending_writes.insert(pending_writes.size(), w);
   endfunction

   function automatic void queue_event(logic [OP_W-1:0] op, logic [ADDR_W-1:0] address,
                                       logic [TIME_W-1:0] now);
      auth_event_type e;
      e.op      = op;
      e.address = address;
      e.now     = now;
      pending_events.insert(pending_events.size(), e);
   endfunction

   // -------------------------------------------------------------------------
   // Gap lengths: mostly none or short, now and then a long one.
   // -------------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // -------------------------------------------------------------------------
   // Predictor: applies one event to the shadow table, returns the answer.
   // -------------------------------------------------------------------------
   function automatic verdict_type predict_verdict(auth_event_type ev);
      verdict_type v;
      int          slot;
      int          i;
      logic [31:0] secs;
      logic [31:0] cap32;
      logic [32:0] sum;
      v     = '0;
      slot  = -1;
      cap32 = {8'd0, ban_cap_cfg};
      for (i = 0; i < TABLE_ENTRIES; i++)
         if (slot < 0 && lockout_table[i].valid && lockout_table[i].address == ev.address)
            slot = i;
      case (ev.op)
         OP_QUERY: begin
            // an expired ban found by a query drops the whole entry
            if (slot >= 0 && lockout_table[slot].active) begin
               if (lockout_table[slot].expiry <= ev.now)
                  lockout_table[slot] = '0;
               else
                  v.is_blocked = 1'b1;
            end
         end
         OP_FAILURE: begin
            if (slot < 0) begin
               // new address takes the lowest free entry, or is dropped
               for (i = 0; i < TABLE_ENTRIES; i++)
                  if (slot < 0 && !lockout_table[i].valid)
                     slot = i;
               if (slot < 0) begin
                  v.table_full = 1'b1;
               end else begin
                  lockout_table[slot]         = '0;
                  lockout_table[slot].valid   = 1'b1;
                  lockout_table[slot].address = ev.address;
               end
            end
            if (slot >= 0) begin
               if (lockout_table[slot].count != COUNT_MAX)
                  lockout_table[slot].count++;
               if (lockout_table[slot].count >= threshold_cfg) begin
                  // double once per earlier ban, stop at the cap
                  secs = {8'd0, ban_initial_cfg};
                  for (i = 0; i < lockout_table[slot].level && secs < cap32; i++)
                     secs = secs << 1;
                  if (secs > cap32)
                     secs = cap32;
                  if (lockout_table[slot].level != COUNT_MAX)
                     lockout_table[slot].level++;
                  sum = {1'b0, ev.now} + {1'b0, secs};
                  lockout_table[slot].expiry = sum[32] ? '1 : sum[31:0];
                  lockout_table[slot].active = 1'b1;
                  lockout_table[slot].count  = '0;
                  v.banned_now  = 1'b1;
                  v.ban_seconds = secs[SECS_W-1:0];
               end
            end
         end
         OP_SUCCESS: begin
            if (slot >= 0)
               lockout_table[slot] = '0;
         end
         default: ;
      endcase
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Event driver: presents queued events, predicts each one on transfer.
   // The valid flag only drops when a gap is due or nothing is queued.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : event_driver
      auth_event_type item;
      verdict_type    v;
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.op             <= OP_QUERY;
         req_bus.source_address <= '0;
         req_bus.current_time   <= '0;
         source_wait = 0;
         foreach (lockout_table[i])
            lockout_table[i] = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            item.op      = req_bus.op;
            item.address = req_bus.source_address;
            item.now     = req_bus.current_time;
            v = predict_verdict(item);
            enqueue_verdict(v);
            events_sent++;
            if (v.banned_now) bans_started++;
            if (v.is_blocked) blocked_answers++;
            if (v.table_full) full_answers++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (source_wait != 0) begin
               source_wait--;
               req_bus.valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               item = pending_events.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.op             <= item.op;
               req_bus.source_address <= item.address;
               req_bus.current_time   <= item.now;
               source_wait = source_gaps_on ? pick_gap() : 0;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Register writer: the shadow registers follow each write transfer.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : reg_writer
      reg_write_type w;
      if (reset) begin
         csr_bus.valid   <= 1'b0;
         csr_bus.index   <= REG_FAIL_THRESHOLD;
         csr_bus.data    <= '0;
         threshold_cfg   = FAIL_THRESHOLD_RESET;
         ban_initial_cfg = BAN_INITIAL_RESET;
         ban_cap_cfg     = BAN_MAX_RESET;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_FAIL_THRESHOLD: threshold_cfg   = csr_bus.data[THR_W-1:0];
               REG_BAN_INITIAL:    ban_initial_cfg = csr_bus.data[SECS_W-1:0];
               REG_BAN_MAX:        ban_cap_cfg     = csr_bus.data[SECS_W-1:0];
               default: ;
            endcase
            reg_writes++;
         end
         if (!csr_bus.valid || csr_bus.ready) begin
            if (pending_writes.size() != 0) begin
               w = pending_writes.pop_front();
               csr_bus.valid <= 1'b1;
               csr_bus.index <= w.index;
               csr_bus.data  <= w.data;
            end else begin
               csr_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result sink: random stalls, plus one long hold-off on request so the
   // core backs up and stalls its input.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : result_sink
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_wait = 0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         sink_wait = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (sink_wait != 0) begin
         sink_wait--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (sink_gaps_on && $urandom_range(0, 3) == 0)
            sink_wait = pick_gap();
      end
   end

   // -------------------------------------------------------------------------
   // Result checker: every result transfer against the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : result_checker
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with nothing outstanding", results_checked);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_bus.is_blocked !== want.is_blocked ||
                rsp_bus.banned_now !== want.banned_now ||
                rsp_bus.ban_seconds !== want.ban_seconds ||
                rsp_bus.table_full !== want.table_full) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"result %0d: expected blk=%0b ban=%0b secs=%0d full=%0b,",
                            " got blk=%0b ban=%0b secs=%0d full=%0b"},
                           results_checked, want.is_blocked, want.banned_now,
                           want.ban_seconds, want.table_full, rsp_bus.is_blocked,
                           rsp_bus.banned_now, rsp_bus.ban_seconds, rsp_bus.table_full);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run after a long stretch with no transfer anywhere.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sequencer helpers
   // -------------------------------------------------------------------------

   // sampled on the falling edge so every rising-edge update has settled
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_bus.valid || expected_verdicts.size() != 0 ||
             pending_writes.size() != 0 || csr_bus.valid);
   endtask

   // registers only change with nothing in flight
   task automatic program_regs(logic [THR_W-1:0] thr, logic [SECS_W-1:0] initial_secs,
                               logic [SECS_W-1:0] cap_secs);
      wait_quiet();
      enqueue_write(REG_FAIL_THRESHOLD, CSR_DAT_W'(thr));
      enqueue_write(REG_BAN_INITIAL, initial_secs);
      enqueue_write(REG_BAN_MAX, cap_secs);
      settings_used++;
      wait_quiet();
   endtask

   // Random traffic over a pool of addresses: mostly failure bursts that
   // lead to bans, then queries that land inside or after the ban window,
   // with successes, unknown addresses, time jumps and unused op codes mixed in.
   task automatic queue_traffic(int unsigned events, int unsigned pool_size,
                                int unsigned burst_max, int unsigned step_max,
                                logic [TIME_W-1:0] start_time);
      logic [ADDR_W-1:0] pool [32];
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] now;
      int unsigned       n;
      int unsigned       r;
      int unsigned       k;
      for (k = 0; k < pool_size; k++)
         pool[k] = $urandom();
      if (pool_size > 2) begin
         pool[0] = '0;
         pool[1] = '1;
      end
      now = start_time;
      n   = 0;
      while (n < events) begin
         r    = $urandom_range(0, 99);
         addr = pool[$urandom_range(0, pool_size - 1)];
         now += $urandom_range(0, step_max);
         if (r < 45) begin
            k = $urandom_range(1, burst_max);
            repeat (k) begin
               queue_event(OP_FAILURE, addr, now);
               now += $urandom_range(0, 1);
               n++;
            end
         end else if (r < 75) begin
            queue_event(OP_QUERY, (r < 72) ? addr : ADDR_W'($urandom()), now);
            n++;
         end else if (r < 87) begin
            queue_event(OP_SUCCESS, (r < 84) ? addr : ADDR_W'($urandom()), now);
            n++;
         end else if (r < 95) begin
            // jump well past most ban windows
            now += $urandom_range(step_max, 40 * step_max + 1);
            queue_event(OP_QUERY, addr, now);
            n++;
         end else begin
            queue_event(OP_UNUSED, $urandom(), $urandom());
            n++;
         end
      end
   endtask

   task automatic run_phase(logic [THR_W-1:0] thr, logic [SECS_W-1:0] initial_secs,
                            logic [SECS_W-1:0] cap_secs, bit gaps_in, bit gaps_out,
                            bit hold_out, int unsigned events, int unsigned pool_size,
                            int unsigned burst_max, int unsigned step_max,
                            logic [TIME_W-1:0] start_time);
      program_regs(thr, initial_secs, cap_secs);
      source_gaps_on = gaps_in;
      sink_gaps_on   = gaps_out;
      queue_traffic(events, pool_size, burst_max, step_max, start_time);
      // receiver holds off while the sender keeps offering
      if (hold_out)
         hold_requests++;
   endtask

   // -------------------------------------------------------------------------
   // Sequencer: reset, directed events, random phases, drain and verdict.
   // -------------------------------------------------------------------------
   initial begin : sequencer
      reset          = 1'b1;
      source_gaps_on = 1'b1;
      sink_gaps_on   = 1'b1;
      hold_requests  = 0;
      holds_served   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: threshold 5, first ban 60 s, cap 3600 s
      queue_event(OP_UNUSED, '1, '1);                // unused op answers zero
      queue_event(OP_QUERY, '0, '0);                 // unknown address
      queue_event(OP_SUCCESS, 32'h1234_5678, 32'd1); // success, unknown address
      repeat (4) queue_event(OP_FAILURE, 32'h0A00_0001, 32'd100);
      queue_event(OP_QUERY, 32'h0A00_0001, 32'd100); // counted, not banned
      queue_event(OP_FAILURE, 32'h0A00_0001, 32'd100); // fifth: 60 s ban
      queue_event(OP_QUERY, 32'h0A00_0001, 32'd159); // still banned
      queue_event(OP_FAILURE, 32'h0A00_0001, 32'd159); // counts while banned
      queue_event(OP_QUERY, 32'h0A00_0001, 32'd160); // expiry equals now: cleared
      queue_event(OP_FAILURE, 32'hC0A8_0001, 32'd200);
      queue_event(OP_SUCCESS, 32'hC0A8_0001, 32'd201); // success erases
      queue_event(OP_QUERY, 32'hC0A8_0001, 32'd202);

      // zero threshold, full-scale lengths, expiry saturation
      program_regs(8'd0, 24'hFF_FFFF, 24'hFF_FFFF);
      queue_event(OP_FAILURE, '1, 32'hFFFF_FF00);
      queue_event(OP_QUERY, '1, '1);
      queue_event(OP_FAILURE, '0, 32'd0);
      queue_event(OP_FAILURE, '0, 32'd1);            // second ban stays at the cap
      queue_event(OP_QUERY, '0, 32'd2);

      // first length above the cap
      program_regs(8'd1, 24'd1000, 24'd300);
      queue_event(OP_FAILURE, 32'h7F00_0001, 32'd5);
      queue_event(OP_QUERY, 32'h7F00_0001, 32'd304);

      // random phases; more addresses than entries in two of them
      run_phase(8'd3, 24'd10, 24'd200, 1, 1, 0, 110, 24, 3, 4,
                TIME_W'($urandom_range(0, 1 << 20)));
      run_phase(8'd1, 24'd1, 24'hFF_FFFF, 1, 1, 0, 100, 2, 4, 2, $urandom());
      run_phase(8'd255, 24'd5, 24'd40, 0, 0, 1, 100, 3, 8, 1, $urandom());
      run_phase(THR_W'($urandom_range(1, 6)), SECS_W'($urandom_range(1, 300)),
                SECS_W'($urandom_range(1, 5000)), 1, 1, 0, 120, 12, 6, 30, $urandom());
      run_phase(8'd2, 24'd1000, 24'd300, 1, 1, 0, 100, 6, 3, 50, $urandom());
      run_phase(8'd0, 24'd0, 24'd0, 1, 0, 0, 90, 20, 2, 5, 32'hFFFF_FF00);
      run_phase(8'd4, 24'hFF_FFFF, 24'hFF_FFFF, 1, 1, 0, 80, 4, 5, 3, 32'hFFFF_F000);
      run_phase(FAIL_THRESHOLD_RESET, BAN_INITIAL_RESET, BAN_MAX_RESET, 1, 1, 1,
                130, 16, 6, 20, $urandom());

      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d events and %0d results, %0d register writes over %0d settings",
               events_sent, results_checked, reg_writes, settings_used);
      $display("predicted %0d bans started, %0d blocked answers, %0d table-full drops",
               bans_started, blocked_answers, full_answers);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches,
                  expected_verdicts.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
